// ===== rtl/core/heat_map_colormap_unit_assert.svh =====
// assertion macros used by the checker
`ifndef HEAT_MAP_COLORMAP_UNIT_ASSERT_SVH
`define HEAT_MAP_COLORMAP_UNIT_ASSERT_SVH

// same-cycle implication
`define HMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/hmc_pkg.sv =====
`default_nettype none
package hmc_pkg;

  localparam int CountW   = 32;
  localparam int ProdW    = 64;
  localparam int RootW    = 32;
  localparam int RemW     = RootW + 3;
  localparam int SqStages = 16;
  localparam int SqSteps  = RootW / SqStages;
  localparam int QuotW    = 11;
  localparam int NumW     = CountW + QuotW;
  localparam int DivStages = 6;
  localparam int DivSteps  = 2;
  localparam logic [QuotW-1:0] VTop = 11'd1535;

  localparam logic [2:0] SEG_BLUE   = 3'd0;
  localparam logic [2:0] SEG_CYAN   = 3'd1;
  localparam logic [2:0] SEG_GREEN  = 3'd2;
  localparam logic [2:0] SEG_BROWN  = 3'd3;
  localparam logic [2:0] SEG_RED    = 3'd4;

  typedef logic [255:0][7:0] rom_t;

  typedef struct packed {
    logic [CountW-1:0] max_cnt;
    logic              err;
  } hmc_side_t;

  localparam logic [63:0] QOne = 64'd1 << 48;

  // shift and subtract quotient, only used while the tables are built
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(x/den) in q48, or e^(-x/den) when neg is set; truncated taylor terms
  function automatic logic [63:0] exp_q48(logic [63:0] x, logic [63:0] den, logic neg);
    logic [63:0] term;
    logic [63:0] ev;
    logic [63:0] od;
    logic        done;
    term = QOne;
    ev   = QOne;
    od   = '0;
    done = 1'b0;
    for (int n = 1; n < 100; n++) begin
      if (!done) begin
        term = udiv64(term * x, den * 64'(n));
        if (term == '0) begin
          done = 1'b1;
        end else if (n[0]) begin
          od = od + term;
        end else begin
          ev = ev + term;
        end
      end
    end
    return neg ? (ev - od) : (ev + od);
  endfunction

  function automatic rom_t build_f0();
    rom_t        rom;
    logic [63:0] e;
    logic [63:0] q;
    for (int x = 0; x < 256; x++) begin
      e = exp_q48(64'(x), 64'd63, 1'b0);
      q = udiv64(64'd26000 * QOne - 64'd453 * e, 64'd100 * QOne);
      rom[x] = q[7:0];
    end
    return rom;
  endfunction

  function automatic rom_t build_f1();
    rom_t        rom;
    logic [63:0] e;
    logic [63:0] q;
    for (int x = 0; x < 256; x++) begin
      e = exp_q48(64'(x), 64'd90, 1'b1);
      q = (64'd271 * (QOne - e)) >> 48;
      rom[x] = q[7:0];
    end
    return rom;
  endfunction

  localparam rom_t F0Rom = build_f0();
  localparam rom_t F1Rom = build_f1();

endpackage
`default_nettype wire

// ===== rtl/core/hmc_isqrt.sv =====
`default_nettype none
module hmc_isqrt (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            in_vld,
  input  wire logic [hmc_pkg::ProdW-1:0]       in_rad,
  input  wire hmc_pkg::hmc_side_t              in_side,
  output logic                                 out_vld,
  output logic [hmc_pkg::RootW-1:0]            out_root,
  output hmc_pkg::hmc_side_t                   out_side
);
  import hmc_pkg::*;

  logic              vld_r  [SqStages];
  logic [ProdW-1:0]  rad_r  [SqStages];
  logic [RemW-1:0]   rem_r  [SqStages];
  logic [RootW-1:0]  root_r [SqStages];
  hmc_side_t         side_r [SqStages];

  for (genvar st = 0; st < SqStages; st++) begin : g_st
    logic              vld_p;
    logic [ProdW-1:0]  rad_p;
    logic [RemW-1:0]   rem_p;
    logic [RootW-1:0]  root_p;
    hmc_side_t         side_p;
    logic [ProdW-1:0]  rad_nxt;
    logic [RemW-1:0]   rem_nxt;
    logic [RootW-1:0]  root_nxt;

    if (st == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = in_side;
    end else begin : g_rest
      assign vld_p  = vld_r[st-1];
      assign rad_p  = rad_r[st-1];
      assign rem_p  = rem_r[st-1];
      assign root_p = root_r[st-1];
      assign side_p = side_r[st-1];
    end

    // two result bits per stage, msb first
    always_comb begin : step
      logic [RemW-1:0] shifted;
      logic [RemW-1:0] trial;
      rad_nxt  = rad_p;
      rem_nxt  = rem_p;
      root_nxt = root_p;
      for (int j = 0; j < SqSteps; j++) begin
        shifted = {rem_nxt[RemW-3:0], rad_nxt[ProdW-1 -: 2]};
        trial   = {1'b0, root_nxt, 2'b01};
        if (shifted >= trial) begin
          rem_nxt  = shifted - trial;
          root_nxt = {root_nxt[RootW-2:0], 1'b1};
        end else begin
          rem_nxt  = shifted;
          root_nxt = {root_nxt[RootW-2:0], 1'b0};
        end
        rad_nxt = rad_nxt << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else if (en) begin
        vld_r[st] <= vld_p;
      end
      if (en) begin
        rad_r[st]  <= rad_nxt;
        rem_r[st]  <= rem_nxt;
        root_r[st] <= root_nxt;
        side_r[st] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[SqStages-1];
  assign out_root = root_r[SqStages-1];
  assign out_side = side_r[SqStages-1];

endmodule
`default_nettype wire

// ===== rtl/core/heat_map_colormap_unit.sv =====
// an accepted input word passes the product, square root, numerator, divide, rom and output registers
// throughput: one word per cycle; the whole pipeline holds while the output is stalled
// the square root runs two bits per stage over 16 stages, the divide two bits over 6
// reset (rst_n low, synchronous) empties the pipeline and sets max_count to 1
`default_nettype none
module heat_map_colormap_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic [0:0]       out_tuser,  // [0] out_of_range
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import hmc_pkg::*;

  logic              en;
  logic [CountW-1:0] max_r;

  // product stage
  logic              p_vld_r;
  logic [ProdW-1:0]  p_r;
  hmc_side_t         p_side_r;

  logic              sq_vld;
  logic [RootW-1:0]  sq_root;
  hmc_side_t         sq_side;

  // scaled numerator stage
  logic              n_vld_r;
  logic [NumW-1:0]   n_r;
  hmc_side_t         n_side_r;

  logic              dv_vld_r  [DivStages];
  logic [NumW-1:0]   dv_rem_r  [DivStages];
  logic [QuotW-1:0]  dv_q_r    [DivStages];
  hmc_side_t         dv_side_r [DivStages];

  // rom stage
  logic              rm_vld_r;
  logic [2:0]        rm_seg_r;
  logic [7:0]        rm_o_r;
  logic [7:0]        rm_a_r;
  logic [7:0]        rm_b_r;
  logic              rm_err_r;
  logic [QuotW-1:0]  v_val;

  logic              o_vld_r;
  logic [23:0]       o_data_r;
  logic              o_err_r;
  logic [7:0]        red_nxt;
  logic [7:0]        grn_nxt;
  logic [7:0]        blu_nxt;
  logic [9:0]        b3;

  assign en        = !o_vld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 32'd1;
    end else if (cfg_valid) begin
      max_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_tvalid;
    end
    if (en) begin
      p_r              <= ProdW'(in_tdata) * ProdW'(max_r);
      p_side_r.max_cnt <= max_r;
      p_side_r.err     <= (max_r == '0) || (in_tdata > max_r);
    end
  end

  hmc_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (p_vld_r),
    .in_rad  (p_r),
    .in_side (p_side_r),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_side)
  );

  // 1535*s as 1024s + 512s - s
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (en) begin
      n_vld_r <= sq_vld;
    end
    if (en) begin
      n_r      <= (NumW'(sq_root) << 10) + (NumW'(sq_root) << 9) - NumW'(sq_root);
      n_side_r <= sq_side;
    end
  end

  for (genvar st = 0; st < DivStages; st++) begin : g_div
    logic              vld_p;
    logic [NumW-1:0]   rem_p;
    logic [QuotW-1:0]  q_p;
    hmc_side_t         side_p;
    logic [NumW-1:0]   rem_nxt;
    logic [QuotW-1:0]  q_nxt;

    if (st == 0) begin : g_first
      assign vld_p  = n_vld_r;
      assign rem_p  = n_r;
      assign q_p    = '0;
      assign side_p = n_side_r;
    end else begin : g_rest
      assign vld_p  = dv_vld_r[st-1];
      assign rem_p  = dv_rem_r[st-1];
      assign q_p    = dv_q_r[st-1];
      assign side_p = dv_side_r[st-1];
    end

    // restoring divide, quotient bits msb first
    always_comb begin : step
      logic [NumW-1:0] dshift;
      int              k;
      rem_nxt = rem_p;
      q_nxt   = q_p;
      for (int j = 0; j < DivSteps; j++) begin
        k = QuotW - 1 - st * DivSteps - j;
        if (k >= 0) begin
          dshift = NumW'(side_p.max_cnt) << k;
          if (rem_nxt >= dshift) begin
            rem_nxt  = rem_nxt - dshift;
            q_nxt[k[3:0]] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[st] <= 1'b0;
      end else if (en) begin
        dv_vld_r[st] <= vld_p;
      end
      if (en) begin
        dv_rem_r[st]  <= rem_nxt;
        dv_q_r[st]    <= q_nxt;
        dv_side_r[st] <= side_p;
      end
    end
  end

  assign v_val = VTop - dv_q_r[DivStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_vld_r <= 1'b0;
    end else if (en) begin
      rm_vld_r <= dv_vld_r[DivStages-1];
    end
    if (en) begin
      rm_seg_r <= v_val[10:8];
      rm_o_r   <= v_val[7:0];
      rm_a_r   <= F0Rom[v_val[7:0]];
      rm_b_r   <= F1Rom[v_val[7:0]];
      rm_err_r <= dv_side_r[DivStages-1].err;
    end
  end

  assign b3 = {2'b00, rm_b_r} + {1'b0, rm_b_r, 1'b0};

  always_comb begin
    red_nxt = '0;
    grn_nxt = '0;
    blu_nxt = '0;
    case (rm_seg_r)
      SEG_BLUE: begin
        blu_nxt = rm_o_r;
      end
      SEG_CYAN: begin
        grn_nxt = rm_b_r;
        blu_nxt = rm_a_r;
      end
      SEG_GREEN: begin
        red_nxt = {1'b0, rm_b_r[7:1]};
        grn_nxt = 8'd255 - b3[9:2];
      end
      SEG_BROWN: begin
        red_nxt = 8'd128 + {1'b0, rm_b_r[7:1]};
        grn_nxt = 8'd63 - {2'b00, rm_b_r[7:2]};
      end
      SEG_RED: begin
        red_nxt = 8'd255;
        grn_nxt = rm_o_r;
      end
      default: begin
        red_nxt = 8'd255;
        grn_nxt = 8'd255;
        blu_nxt = 8'd255 - rm_a_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= rm_vld_r;
    end
    if (en) begin
      o_data_r <= rm_err_r ? 24'd0 : {blu_nxt, grn_nxt, red_nxt};
      o_err_r  <= rm_err_r;
    end
  end

  assign out_tvalid   = o_vld_r;
  assign out_tdata    = o_data_r;
  assign out_tuser[0] = o_err_r;

endmodule
`default_nettype wire

// ===== rtl/core/hmc_checker.sv =====
`default_nettype none
`include "heat_map_colormap_unit_assert.svh"
module hmc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [31:0] cfg_data
);
  logic unused_ok;
  assign unused_ok = in_tvalid ^ (^in_tdata) ^ cfg_valid ^ cfg_ready ^ (^cfg_data);

  `HMC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `HMC_ASSERT_NOW(a_err_black, out_tvalid && out_tuser[0], out_tdata == 24'd0)
  `HMC_ASSERT_NOW(a_empty_ready, !out_tvalid, in_tready)
  `HMC_ASSERT_NOW(a_stall_back, out_tvalid && !out_tready, !in_tready)

endmodule

bind heat_map_colormap_unit hmc_checker u_hmc_checker (.*);
`default_nettype wire

// ===== test/heat_map_colormap_checker.sv =====
module heat_map_colormap_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       oor;
  } colour_t;

  localparam longint unsigned QOneLocal = 64'd1 << 48;

  logic [7:0]  fall_curve [256];
  logic [7:0]  rise_curve [256];
  logic [31:0] max_cnt;
  colour_t     colours_due [$];

  // truncated taylor series in q48; neg alternates the odd terms
  function automatic longint unsigned exp_fixed(longint unsigned x, longint unsigned den,
                                                bit neg);
    longint unsigned term, even_sum, odd_sum;
    term = QOneLocal;
    even_sum = QOneLocal;
    odd_sum = 0;
    for (int n = 1; n < 100; n++) begin
      term = term * x / (den * n);
      if (term == 0) break;
      if (n % 2 == 1) odd_sum += term;
      else even_sum += term;
    end
    return neg ? even_sum - odd_sum : even_sum + odd_sum;
  endfunction

  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic colour_t colour_for(logic [31:0] cnt, logic [31:0] mx);
    colour_t         c;
    longint unsigned s, v, o, a, b;
    c = '0;
    if (mx == 0 || cnt > mx) begin
      c.oor = 1'b1;
      return c;
    end
    s = root_of(longint'(cnt) * longint'(mx));
    v = 1535 - (1535 * s) / mx;
    o = v & 255;
    a = fall_curve[o];
    b = rise_curve[o];
    case (v >> 8)
      0: c.blue = 8'(o);
      1: begin
        c.green = 8'(b);
        c.blue = 8'(a);
      end
      2: begin
        c.red = 8'(b / 2);
        c.green = 8'(255 - (3 * b) / 4);
      end
      3: begin
        c.red = 8'(128 + b / 2);
        c.green = 8'(63 - b / 4);
      end
      4: begin
        c.red = 8'd255;
        c.green = 8'(o);
      end
      default: begin
        c.red = 8'd255;
        c.green = 8'd255;
        c.blue = 8'(255 - a);
      end
    endcase
    return c;
  endfunction

  initial begin
    longint unsigned e;
    for (int x = 0; x < 256; x++) begin
      e = exp_fixed(x, 63, 1'b0);
      fall_curve[x] = 8'((26000 * QOneLocal - 453 * e) / (100 * QOneLocal));
      e = exp_fixed(x, 90, 1'b1);
      rise_curve[x] = 8'((271 * (QOneLocal - e)) >> 48);
    end
  end

  assign pending = colours_due.size();

  always @(posedge clk) begin
    colour_t got, want;
    if (!rst_n) begin
      max_cnt <= 32'd1;
      errors = 0;
      colours_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_cnt <= cfg_data;
      if (in_tvalid && in_tready) colours_due.push_back(colour_for(in_tdata, max_cnt));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser[0]};
        if (colours_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected colour word %h", got);
        end else begin
          want = colours_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("colour mismatch: rgb exp %h %h %h oor %b, got %h %h %h oor %b",
                       want.red, want.green, want.blue, want.oor,
                       got.red, got.green, got.blue, got.oor);
          end
        end
      end
    end
  end
endmodule

// ===== test/heat_map_colormap_unit_test.sv =====
module heat_map_colormap_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Limit = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  int          errors, pending, cycles;
  int          idle_pct, stall_pct;
  bit          hold_out;

  heat_map_colormap_unit dut (.*);

  heat_map_colormap_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= hold_out ? 1'b0 : ($urandom_range(99) >= stall_pct);

  task automatic push_count(logic [31:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_max(logic [31:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_count(logic [31:0] m);
    int r;
    r = $urandom_range(99);
    if (m != 0 && r < 85) return $urandom_range(m, 0);
    if (m != 32'hFFFF_FFFF && r < 95) return $urandom_range(32'hFFFF_FFFF, m + 1);
    return $urandom;
  endfunction

  initial begin
    logic [31:0] maxes [8];
    logic [31:0] m;
    cycles = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_valid = 0;
    cfg_data = 0;
    out_tready = 0;
    hold_out = 0;
    idle_pct = 0;
    stall_pct = 0;
    maxes = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd100000, 32'd7, $urandom,
              32'h8000_0000, 32'd1535};
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // reset value first, before any write
    push_count(0);
    push_count(1);
    push_count(2);
    for (int p = 0; p < 8; p++) begin
      m = maxes[p];
      write_max(m);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      push_count(0);
      push_count(m);
      push_count(m - 1);
      push_count(m + 1);
      push_count(32'hFFFF_FFFF);
      if (p == 3) begin
        // points spread so that each ramp gets at least one
        for (int k = 1; k < 12; k++) push_count(m / 144 * k * k);
      end
      if (p == 1) begin
        idle_pct = 0;
        fork
          begin
            hold_out = 1;
            repeat (300) @(negedge clk);
            hold_out = 0;
          end
        join_none
      end
      for (int i = 0; i < 250; i++) begin
        push_count(pick_count(m));
        if (p == 1 && i == 100) idle_pct = 69;
        if (i == 150) drain();
      end
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
